[design/mtep_pkg.sv]
// Types, codes and constants shared by the MP table entry parser modules.
package mtep_pkg;

	localparam int unsigned LEN_W   = 16;
	localparam int unsigned COUNT_W = 5;
	localparam int unsigned OFF_W   = 5;

	// Most CPU records the block itself can hold; the register limit is capped by it.
	localparam logic [COUNT_W-1:0] MAX_CPUS = 5'd16;

	localparam logic [OFF_W-1:0] PROC_ENTRY_BYTES  = 5'd20;
	localparam logic [OFF_W-1:0] OTHER_ENTRY_BYTES = 5'd8;

	localparam logic [7:0] ENTRY_PROCESSOR = 8'd0;
	localparam logic [7:0] ENTRY_LAST_KNOWN = 8'd4;

	localparam logic [OFF_W-1:0] OFFSET_APIC_ID = 5'd1;
	localparam logic [OFF_W-1:0] OFFSET_FLAGS   = 5'd3;

	typedef enum logic {
		KIND_START = 1'b0,
		KIND_BYTE  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		STOP_END_OF_AREA = 2'd0,
		STOP_LIMIT       = 2'd1,
		STOP_UNKNOWN     = 2'd2
	} stop_reason_t;

	typedef enum logic {
		CFG_ENTRIES_LENGTH = 1'b0,
		CFG_MAX_CPUS       = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] table_byte;
	} item_t;

	typedef struct packed {
		logic               record_valid;
		logic [7:0]         apic_id;
		logic               is_bsp;
		logic [3:0]         cpu_index;
		logic               finished;
		logic [COUNT_W-1:0] cpu_count;
		logic [1:0]         stop_reason;
	} result_t;

	typedef struct packed {
		logic [LEN_W-1:0]   entries_length;
		logic [COUNT_W-1:0] max_cpus;
	} cfg_t;

endpackage

[design/mtep_cfg_regs.sv]
// Configuration registers of the MP table entry parser.
module mtep_cfg_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [15:0]          cfg_data,
	output mtep_pkg::cfg_t       cfg
);

	mtep_pkg::cfg_t cfg_q;

	// Writes are taken in every cycle.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.entries_length <= '0;
			cfg_q.max_cpus       <= mtep_pkg::MAX_CPUS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (mtep_pkg::cfg_index_t'(cfg_index))
				mtep_pkg::CFG_ENTRIES_LENGTH: begin
					cfg_q.entries_length <= cfg_data;
				end
				mtep_pkg::CFG_MAX_CPUS: begin
					cfg_q.max_cpus <= cfg_data[mtep_pkg::COUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[design/mtep_parse_core.sv]
// Parse state registers and the per-item step logic of the MP table entry parser.
module mtep_parse_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  mtep_pkg::item_t      item,
	input  mtep_pkg::cfg_t       cfg,
	output logic                 has_result,
	output mtep_pkg::result_t    result
);

	logic [mtep_pkg::LEN_W-1:0]   byte_position_q, byte_position_d;
	logic [mtep_pkg::OFF_W-1:0]   entry_offset_q, entry_offset_d;
	logic [mtep_pkg::OFF_W-1:0]   entry_size_q, entry_size_d;
	logic                         entry_is_processor_q, entry_is_processor_d;
	logic [7:0]                   held_apic_id_q, held_apic_id_d;
	logic [mtep_pkg::COUNT_W-1:0] records_found_q, records_found_d;
	logic                         parse_done_q, parse_done_d;

	logic [mtep_pkg::COUNT_W-1:0] cpu_limit;
	logic [mtep_pkg::OFF_W-1:0]   offset_inc;
	logic                         record;

	assign cpu_limit = (cfg.max_cpus < mtep_pkg::MAX_CPUS) ? cfg.max_cpus : mtep_pkg::MAX_CPUS;

	always_comb begin
		byte_position_d      = byte_position_q;
		entry_offset_d       = entry_offset_q;
		entry_size_d         = entry_size_q;
		entry_is_processor_d = entry_is_processor_q;
		held_apic_id_d       = held_apic_id_q;
		records_found_d      = records_found_q;
		parse_done_d         = parse_done_q;
		record               = 1'b0;
		offset_inc           = '0;
		has_result           = 1'b0;
		result               = '0;

		if (item.kind == mtep_pkg::KIND_START) begin
			// A start always abandons the current table.
			byte_position_d      = '0;
			entry_offset_d       = '0;
			entry_size_d         = '0;
			entry_is_processor_d = 1'b0;
			held_apic_id_d       = '0;
			records_found_d      = '0;
			parse_done_d         = 1'b0;
			if (cfg.entries_length == '0) begin
				parse_done_d       = 1'b1;
				has_result         = 1'b1;
				result.finished    = 1'b1;
				result.stop_reason = mtep_pkg::STOP_END_OF_AREA;
			end else if (cpu_limit == '0) begin
				parse_done_d       = 1'b1;
				has_result         = 1'b1;
				result.finished    = 1'b1;
				result.stop_reason = mtep_pkg::STOP_LIMIT;
			end
		end else if (!parse_done_q) begin
			if (entry_offset_q == '0 && item.table_byte > mtep_pkg::ENTRY_LAST_KNOWN) begin
				// Unknown entry type: stop without touching the position counters.
				parse_done_d       = 1'b1;
				has_result         = 1'b1;
				result.finished    = 1'b1;
				result.stop_reason = mtep_pkg::STOP_UNKNOWN;
				result.cpu_count   = records_found_q;
			end else begin
				if (entry_offset_q == '0) begin
					if (item.table_byte == mtep_pkg::ENTRY_PROCESSOR) begin
						entry_size_d         = mtep_pkg::PROC_ENTRY_BYTES;
						entry_is_processor_d = 1'b1;
					end else begin
						entry_size_d         = mtep_pkg::OTHER_ENTRY_BYTES;
						entry_is_processor_d = 1'b0;
					end
				end else if (entry_is_processor_q) begin
					if (entry_offset_q == mtep_pkg::OFFSET_APIC_ID) begin
						held_apic_id_d = item.table_byte;
					end else if (entry_offset_q == mtep_pkg::OFFSET_FLAGS &&
							item.table_byte[0]) begin
						record          = 1'b1;
						records_found_d = records_found_q + 1'b1;
					end
				end

				offset_inc      = entry_offset_q + 1'b1;
				entry_offset_d  = (offset_inc >= entry_size_d) ? '0 : offset_inc;
				byte_position_d = byte_position_q + 1'b1;

				if (record) begin
					result.record_valid = 1'b1;
					result.apic_id      = held_apic_id_q;
					result.is_bsp       = item.table_byte[1];
					result.cpu_index    = records_found_q[3:0];
				end
				result.cpu_count = records_found_d;

				if (byte_position_d == '0 || byte_position_d >= cfg.entries_length) begin
					parse_done_d       = 1'b1;
					has_result         = 1'b1;
					result.finished    = 1'b1;
					result.stop_reason = mtep_pkg::STOP_END_OF_AREA;
				end else if (entry_offset_d == '0 && records_found_d >= cpu_limit) begin
					parse_done_d       = 1'b1;
					has_result         = 1'b1;
					result.finished    = 1'b1;
					result.stop_reason = mtep_pkg::STOP_LIMIT;
				end else if (record) begin
					has_result = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q      <= '0;
			entry_offset_q       <= '0;
			entry_size_q         <= '0;
			entry_is_processor_q <= 1'b0;
			held_apic_id_q       <= '0;
			records_found_q      <= '0;
			parse_done_q         <= 1'b1;
		end else if (step) begin
			byte_position_q      <= byte_position_d;
			entry_offset_q       <= entry_offset_d;
			entry_size_q         <= entry_size_d;
			entry_is_processor_q <= entry_is_processor_d;
			held_apic_id_q       <= held_apic_id_d;
			records_found_q      <= records_found_d;
			parse_done_q         <= parse_done_d;
		end
	end

	// The offset inside an entry never reaches the entry's size.
	a_offset_in_entry: assert property (@(posedge clk) disable iff (!arst_n)
		entry_offset_q == '0 || entry_offset_q < entry_size_q)
		else $error("entry offset ran past the entry size");

	// Only the two known entry sizes, or none before the first type byte.
	a_entry_size_known: assert property (@(posedge clk) disable iff (!arst_n)
		entry_size_q == '0 || entry_size_q == mtep_pkg::PROC_ENTRY_BYTES ||
		entry_size_q == mtep_pkg::OTHER_ENTRY_BYTES)
		else $error("entry size is not a known entry length");

	// A record comes only from the flags byte of a processor entry.
	a_record_at_flags: assert property (@(posedge clk) disable iff (!arst_n)
		step && has_result && result.record_valid |->
		entry_is_processor_q && entry_offset_q == mtep_pkg::OFFSET_FLAGS && !parse_done_q)
		else $error("record emitted outside a processor flags byte");

	// A finished result leaves the parser done.
	a_finish_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		step && has_result && result.finished |=> parse_done_q)
		else $error("parser not done after a finished result");

endmodule

[design/mp_table_entry_parser.sv]
// Top level of the MP configuration table entry parser.
// This block walks the entry area of a multiprocessor configuration table, with the
// header already stripped, one byte per transfer on the item channel after a start
// transfer (kind 0). Processor entries with the enabled flag set yield a CPU record;
// a result transfer appears only when a record is made or the parse ends, and both can
// share one transfer. The block takes one item per clock cycle while item_stall is
// low; an accepted item is held in the input register for the single step of the
// parse-state logic, whose outcome lands in the result register. The result register
// parts the two channels, so an empty input register accepts a new item while a
// result waits to be taken, and input stalls only when the result register is full
// and stalled and an item already sits in the input register. The record limit is the
// smaller of the max_cpus register and the built-in limit of 16. Configuration writes
// are accepted in every cycle and are meant to be made while no parse is in flight.
module mp_table_entry_parser (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                item_valid,
	output logic                item_stall,
	input  mtep_pkg::item_t     item,

	output logic                result_valid,
	input  logic                result_stall,
	output mtep_pkg::result_t   result,

	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data
);

	mtep_pkg::cfg_t    cfg;
	mtep_pkg::item_t   item_s1;
	logic              item_valid_s1;
	mtep_pkg::result_t step_result;
	logic              step_has_result;
	mtep_pkg::result_t result_q;
	logic              result_valid_q;

	// The result register can take a new value when it is empty or being drained.
	logic out_free;
	// The held item is processed in the cycle the result register can take its outcome.
	logic step;

	assign out_free   = !result_valid_q || !result_stall;
	assign step       = item_valid_s1 && out_free;
	assign item_stall = item_valid_s1 && !out_free;

	mtep_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register: loads whenever the incoming transfer is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	mtep_parse_core u_parse_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.item       (item_s1),
		.cfg        (cfg),
		.has_result (step_has_result),
		.result     (step_result)
	);

	// Result register: an item that causes no result simply clears it once drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= step && step_has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (step && step_has_result) begin
			result_q <= step_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[sim/mp_table_checker.sv]
// Checker that predicts and compares the results of the MP table entry parser.
module mp_table_checker
	import mtep_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_stall,
	input  item_t       item,
	input  logic        result_valid,
	input  logic        result_stall,
	input  result_t     result,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output int          failures = 0,
	output int          pending = 0,
	output int          taken = 0
);

	// Register copies.
	logic [LEN_W-1:0]   area_len = '0;
	logic [COUNT_W-1:0] cpu_cap = MAX_CPUS;

	// Parse state.
	logic [LEN_W-1:0]   pos = '0;
	logic [OFF_W-1:0]   off = '0;
	logic [OFF_W-1:0]   size = '0;
	logic               in_proc = 1'b0;
	logic [7:0]         held_apic = '0;
	logic [COUNT_W-1:0] found = '0;
	logic               done = 1'b1;

	result_t parse_results_due[$];

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
		failures++;
	endtask

	// Applies one accepted item to the parse state and queues the result it causes, if any.
	task automatic walk_entry_area(input item_t it);
		result_t r;
		logic rec;
		logic [COUNT_W-1:0] cap;
		r = '0;
		rec = 1'b0;
		cap = (cpu_cap < MAX_CPUS) ? cpu_cap : MAX_CPUS;
		if (it.kind == KIND_START) begin
			pos = '0;
			off = '0;
			size = '0;
			in_proc = 1'b0;
			held_apic = '0;
			found = '0;
			done = 1'b0;
			if (area_len == 0) begin
				done = 1'b1;
				r.finished = 1'b1;
				r.stop_reason = STOP_END_OF_AREA;
				parse_results_due.push_back(r);
			end else if (cap == 0) begin
				done = 1'b1;
				r.finished = 1'b1;
				r.stop_reason = STOP_LIMIT;
				parse_results_due.push_back(r);
			end
			return;
		end
		if (done)
			return;
		if (off == 0) begin
			if (it.table_byte == ENTRY_PROCESSOR) begin
				size = PROC_ENTRY_BYTES;
				in_proc = 1'b1;
			end else if (it.table_byte <= ENTRY_LAST_KNOWN) begin
				size = OTHER_ENTRY_BYTES;
				in_proc = 1'b0;
			end else begin
				done = 1'b1;
				r.finished = 1'b1;
				r.cpu_count = found;
				r.stop_reason = STOP_UNKNOWN;
				parse_results_due.push_back(r);
				return;
			end
		end else if (in_proc) begin
			if (off == OFFSET_APIC_ID) begin
				held_apic = it.table_byte;
			end else if (off == OFFSET_FLAGS && it.table_byte[0]) begin
				rec = 1'b1;
				r.record_valid = 1'b1;
				r.apic_id = held_apic;
				r.is_bsp = it.table_byte[1];
				r.cpu_index = found[3:0];
				found = found + 1'b1;
			end
		end
		off = off + 1'b1;
		if (off >= size)
			off = '0;
		pos = pos + 1'b1;
		r.cpu_count = found;
		if (pos == 0 || pos >= area_len) begin
			done = 1'b1;
			r.finished = 1'b1;
			r.stop_reason = STOP_END_OF_AREA;
			parse_results_due.push_back(r);
		end else if (off == 0 && found >= cap) begin
			done = 1'b1;
			r.finished = 1'b1;
			r.stop_reason = STOP_LIMIT;
			parse_results_due.push_back(r);
		end else if (rec) begin
			parse_results_due.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			area_len = '0;
			cpu_cap = MAX_CPUS;
			pos = '0;
			off = '0;
			size = '0;
			in_proc = 1'b0;
			held_apic = '0;
			found = '0;
			done = 1'b1;
			parse_results_due.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_ENTRIES_LENGTH)
					area_len = cfg_data;
				else
					cpu_cap = cfg_data[COUNT_W-1:0];
			end
			if (item_valid && !item_stall) begin
				// Every transfer counts, ignored bytes included.
				taken++;
				walk_entry_area(item);
			end
			if (result_valid && !result_stall) begin
				if (parse_results_due.size() == 0) begin
					report_mismatch("result with nothing expected, value", result, 0);
				end else begin
					want = parse_results_due.pop_front();
					if (result.record_valid !== want.record_valid)
						report_mismatch("record_valid", result.record_valid, want.record_valid);
					if (result.apic_id !== want.apic_id)
						report_mismatch("apic_id", result.apic_id, want.apic_id);
					if (result.is_bsp !== want.is_bsp)
						report_mismatch("is_bsp", result.is_bsp, want.is_bsp);
					if (result.cpu_index !== want.cpu_index)
						report_mismatch("cpu_index", result.cpu_index, want.cpu_index);
					if (result.finished !== want.finished)
						report_mismatch("finished", result.finished, want.finished);
					if (result.cpu_count !== want.cpu_count)
						report_mismatch("cpu_count", result.cpu_count, want.cpu_count);
					if (result.stop_reason !== want.stop_reason)
						report_mismatch("stop_reason", result.stop_reason, want.stop_reason);
				end
			end
			pending = parse_results_due.size();
		end
	end

endmodule

[sim/testbench.sv]
// Top of the parser testbench: clock, reset, stimulus phases and the final verdict.
module testbench;
	import mtep_pkg::*;

	// The block holds each item in its input register before the parse step; this margin covers items that make no result.
	localparam int DRAIN_CYCLES = 8;
	localparam int ITEMS_PER_PHASE = 425;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	item_t       item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_ENTRIES_LENGTH;
	logic [15:0] cfg_data = '0;

	int failures;
	int pending;
	int taken;

	// Percent of cycles in which the sender holds back or the receiver stalls.
	int unsigned gap_pct = 0;
	int unsigned stall_pct = 0;
	// Entry area length currently programmed, used to size the byte streams.
	int unsigned table_len = 0;
	int unsigned cycles = 0;

	mp_table_entry_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	mp_table_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.failures(failures),
		.pending(pending),
		.taken(taken)
	);

	always #5 clk = ~clk;

	// The receiver decides afresh at every falling edge whether to stall the result channel.
	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	// A run that hangs is cut off here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Presents one item, possibly after some idle cycles, and returns at the rising edge
	// where the transfer happens. The payload is held steady while the block stalls.
	task automatic send_item(input kind_t k, input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= {k, b};
		do @(posedge clk); while (item_stall);
	endtask

	// Writes one register; only called while the block is idle.
	task automatic write_reg(input cfg_index_t idx, input logic [15:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stops sending and waits until every expected result has come back, then lets the
	// pipeline empty of items that make no result.
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Streams entries of random content until the byte budget is spent. Most entries are
	// well formed processor or skipped entries; a few are unknown types, cut-short entries
	// that throw the framing off, or a fresh start in the middle of the table.
	task automatic send_entries(input int unsigned budget);
		logic [7:0] ent [20];
		logic [7:0] flags;
		int unsigned sent;
		int unsigned n;
		int unsigned pick;
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(99);
			if (pick < 3) begin
				send_item(KIND_START, 8'($urandom_range(255)));
				continue;
			end
			if (pick < 6) begin
				send_item(KIND_BYTE, 8'($urandom_range(5, 255)));
				sent++;
				continue;
			end
			for (int i = 0; i < 20; i++)
				ent[i] = 8'($urandom_range(255));
			if (pick < 70) begin
				// Processor entry; the enabled flag is set in most of them.
				flags = 8'($urandom_range(255));
				if ($urandom_range(99) < 80)
					flags[0] = 1'b1;
				ent[0] = ENTRY_PROCESSOR;
				ent[3] = flags;
				n = PROC_ENTRY_BYTES;
			end else begin
				ent[0] = 8'($urandom_range(1, ENTRY_LAST_KNOWN));
				n = OTHER_ENTRY_BYTES;
			end
			if ($urandom_range(99) < 3)
				n = $urandom_range(1, n - 1);
			for (int i = 0; i < n && sent < budget; i++) begin
				send_item(KIND_BYTE, ent[i]);
				sent++;
			end
		end
	endtask

	// Picks a new length and CPU limit, programs both, and runs a few tables with them.
	// Sometimes the old parse is carried on under the new settings before the first start.
	task automatic run_setting();
		logic [15:0] len;
		logic [COUNT_W-1:0] cap;
		int unsigned tables;
		settle();
		case ($urandom_range(11))
			0:       len = 16'($urandom_range(0, 4));
			1, 2, 3, 4, 5, 6: len = 16'($urandom_range(5, 120));
			7, 8:    len = 16'($urandom_range(121, 300));
			9:       len = 16'hFFFF;
			10:      len = 16'($urandom_range(0, 65535));
			default: len = 16'($urandom_range(19, 21));
		endcase
		case ($urandom_range(7))
			0:       cap = '0;
			1:       cap = 5'd1;
			2:       cap = 5'($urandom_range(2, 4));
			3:       cap = MAX_CPUS;
			4:       cap = 5'($urandom_range(17, 31));
			default: cap = 5'($urandom_range(1, 16));
		endcase
		write_reg(CFG_ENTRIES_LENGTH, len);
		// The upper data bits are not part of the limit; they are filled at random.
		write_reg(CFG_MAX_CPUS, {11'($urandom_range(0, 2047)), cap});
		table_len = len;
		if ($urandom_range(3) == 0)
			send_entries($urandom_range(1, 30));
		tables = $urandom_range(1, 4);
		repeat (tables) begin
			send_item(KIND_START, 8'($urandom_range(255)));
			if (table_len <= 300)
				send_entries(table_len + $urandom_range(0, 6));
			else
				send_entries($urandom_range(40, 300));
		end
	endtask

	initial begin
		int unsigned goal;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// A byte before any start is ignored, and a start with a zero length ends at once.
		send_item(KIND_BYTE, 8'hA5);
		send_item(KIND_START, 8'hFF);
		// Zero length and zero limit together: end of area wins.
		settle();
		write_reg(CFG_MAX_CPUS, 16'h0000);
		send_item(KIND_START, 8'h00);
		// Full length with a zero limit stops on the limit right at the start.
		settle();
		write_reg(CFG_ENTRIES_LENGTH, 16'hFFFF);
		send_item(KIND_START, 8'h00);
		// A processor entry cut off right after its flags: the record and the end of the
		// area share one result. Upper data bits of the limit write are all set.
		settle();
		write_reg(CFG_MAX_CPUS, 16'hFFF0);
		write_reg(CFG_ENTRIES_LENGTH, 16'd4);
		send_item(KIND_START, 8'h00);
		send_item(KIND_BYTE, ENTRY_PROCESSOR);
		send_item(KIND_BYTE, 8'hFF);
		send_item(KIND_BYTE, 8'h00);
		send_item(KIND_BYTE, 8'h03);
		// Flags past the end of the area: no record.
		settle();
		write_reg(CFG_ENTRIES_LENGTH, 16'd3);
		send_item(KIND_START, 8'h00);
		send_item(KIND_BYTE, ENTRY_PROCESSOR);
		send_item(KIND_BYTE, 8'h12);
		send_item(KIND_BYTE, 8'h01);
		// Highest known type, skipped until the area runs out.
		send_item(KIND_START, 8'h00);
		send_item(KIND_BYTE, ENTRY_LAST_KNOWN);
		send_item(KIND_BYTE, 8'h7F);
		send_item(KIND_BYTE, 8'h80);
		// Unknown type stops the parse; the byte after it is ignored.
		send_item(KIND_START, 8'h00);
		send_item(KIND_BYTE, 8'hFF);
		send_item(KIND_BYTE, 8'h00);

		// Random tables under each idling pattern in turn.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 61;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 61;
				end
				default: begin
					gap_pct = 17;
					stall_pct = 17;
				end
			endcase
			goal = taken + ITEMS_PER_PHASE;
			while (taken < goal)
				run_setting();
		end

		settle();
		if (failures == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[sim.f]
design/mtep_pkg.sv
design/mtep_cfg_regs.sv
design/mtep_parse_core.sv
design/mp_table_entry_parser.sv
sim/mp_table_checker.sv
sim/testbench.sv
